>>> hdl/assert_macros.svh
// Assertion helpers used by euler_angles_to_basis_vectors_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define EAB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define EAB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/eab_pkg.sv
// ----------------------------------------------------------------------------
// eab_pkg
// Shared types, constants and helpers of the Euler angle to basis vector unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eab_pkg;

    // Internal fixed point: unsigned Q1.30 for sine/cosine
    localparam int unsigned IFB = 30;
    localparam logic [30:0] ONE_Q = 31'(1) << IFB;
    localparam logic [60:0] HALF_P = 61'(1) << (IFB - 1);

    // pi/180 in Q30
    localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;

    // Taylor denominators, innermost Horner term first
    localparam int unsigned NUM_STEPS = 6;
    localparam int unsigned SIN_DEN [5] = '{110, 72, 42, 20, 6};
    localparam int unsigned COS_DEN [6] = '{132, 90, 56, 30, 12, 2};

    // Sine/cosine pipeline depth: reduction and scaling, Horner pairs, final fold
    localparam int unsigned SC_STAGES = 7 + 2 * NUM_STEPS;

    // Quadrant of the reduced angle
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // Input beat
    typedef struct packed {
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic signed [15:0] roll_angle;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        logic signed [15:0] fwd_x;
        logic signed [15:0] fwd_y;
        logic signed [15:0] fwd_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
    } t_out_beat;

    // Signed Q30 product, rounded half away from zero
    function automatic logic signed [31:0] smul_q(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        logic [63:0] m;
        p = 64'(a) * 64'(b);
        m = p[63] ? 64'(-p) : 64'(p);
        m = (m + 64'(HALF_P)) >> IFB;
        return p[63] ? -32'(m) : 32'(m);
    endfunction

endpackage

`default_nettype wire

>>> hdl/euler_angles_to_basis_vectors_unit.sv
// ----------------------------------------------------------------------------
// euler_angles_to_basis_vectors_unit
// Pitch/yaw/roll to forward, right and up unit vectors in saturated Q1.15.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle unless the output stalls; 19 stages of sine/cosine,
// then two product stages, one sum stage and one rounding/saturation stage.
// Each stage holds while its successor is full and stalled, so bubbles close up.
// Reset: synchronous, active low; clears all stage valid bits, no data reset.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module euler_angles_to_basis_vectors_unit #(
    parameter int OUT_FRAC_BITS   = 15,
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire eab_pkg::t_in_beat   i_in_data,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output eab_pkg::t_out_beat       o_out_data
);

    localparam int SC = int'(eab_pkg::SC_STAGES);
    localparam int NS = SC + 4;
    localparam int SH = 30 - OUT_FRAC_BITS;
    localparam logic [33:0] RND_HALF = (SH > 0) ? (34'(1) << (SH - 1)) : 34'(0);

    // Q30 to output format, rounded half away from zero, saturated
    function automatic logic signed [15:0] to_out(input logic signed [32:0] v);
        logic signed [33:0] vx;
        logic [33:0]        m;
        logic signed [17:0] r;
        vx = 34'(v);
        m  = vx[33] ? 34'(-vx) : 34'(vx);
        m  = (m + RND_HALF) >> SH;
        if (m > 34'h10000) begin
            m = 34'h10000;
        end
        r = vx[33] ? -18'(m) : 18'(m);
        if (r > 18'sd32767) begin
            return 16'sh7fff;
        end else if (r < -18'sd32768) begin
            return 16'sh8000;
        end
        return 16'(r);
    endfunction

    // Stage valids and per-stage advance
    logic [NS-1:0] r_v;
    logic [NS-1:0] s_en;

    always_comb begin
        s_en[NS-1] = !r_v[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            s_en[k] = !r_v[k] || s_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (s_en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (s_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_in_ready  = s_en[0];
    assign o_out_valid = r_v[NS-1];

    // Sine/cosine of each angle
    logic signed [31:0] w_sp, w_cp, w_sy, w_cy, w_sr, w_cr;

    eab_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
        .i_clk   (i_clk),
        .i_en    (s_en[SC-1:0]),
        .i_angle (i_in_data.pitch_angle),
        .o_sin   (w_sp),
        .o_cos   (w_cp)
    );

    eab_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_yaw (
        .i_clk   (i_clk),
        .i_en    (s_en[SC-1:0]),
        .i_angle (i_in_data.yaw_angle),
        .o_sin   (w_sy),
        .o_cos   (w_cy)
    );

    eab_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
        .i_clk   (i_clk),
        .i_en    (s_en[SC-1:0]),
        .i_angle (i_in_data.roll_angle),
        .o_sin   (w_sr),
        .o_cos   (w_cr)
    );

    // First product stage
    logic signed [31:0] r_srsp, r_crsp, r_cpcy, r_cpsy, r_nsp, r_srcp, r_crcp;
    logic signed [31:0] r_crsy, r_crcy, r_srsy, r_srcy, r_sy1, r_cy1;

    always_ff @(posedge i_clk) begin
        if (s_en[SC]) begin
            r_srsp <= eab_pkg::smul_q(w_sr, w_sp);
            r_crsp <= eab_pkg::smul_q(w_cr, w_sp);
            r_cpcy <= eab_pkg::smul_q(w_cp, w_cy);
            r_cpsy <= eab_pkg::smul_q(w_cp, w_sy);
            r_nsp  <= -w_sp;
            r_srcp <= eab_pkg::smul_q(w_sr, w_cp);
            r_crcp <= eab_pkg::smul_q(w_cr, w_cp);
            r_crsy <= eab_pkg::smul_q(w_cr, w_sy);
            r_crcy <= eab_pkg::smul_q(w_cr, w_cy);
            r_srsy <= eab_pkg::smul_q(w_sr, w_sy);
            r_srcy <= eab_pkg::smul_q(w_sr, w_cy);
            r_sy1  <= w_sy;
            r_cy1  <= w_cy;
        end
    end

    // Second product stage: three-factor terms; the other terms ride along
    logic signed [31:0] r_fx2, r_fy2, r_fz2, r_rz2, r_uz2;
    logic signed [31:0] r_ax, r_ay, r_bx, r_by;
    logic signed [31:0] r_crsy2, r_crcy2, r_srsy2, r_srcy2;

    always_ff @(posedge i_clk) begin
        if (s_en[SC+1]) begin
            r_fx2   <= r_cpcy;
            r_fy2   <= r_cpsy;
            r_fz2   <= r_nsp;
            r_rz2   <= -r_srcp;
            r_uz2   <= r_crcp;
            r_ax    <= eab_pkg::smul_q(r_srsp, r_cy1);
            r_ay    <= eab_pkg::smul_q(r_srsp, r_sy1);
            r_bx    <= eab_pkg::smul_q(r_crsp, r_cy1);
            r_by    <= eab_pkg::smul_q(r_crsp, r_sy1);
            r_crsy2 <= r_crsy;
            r_crcy2 <= r_crcy;
            r_srsy2 <= r_srsy;
            r_srcy2 <= r_srcy;
        end
    end

    // Sum stage
    logic signed [32:0] r_fx3, r_fy3, r_fz3, r_rx3, r_ry3, r_rz3, r_ux3, r_uy3, r_uz3;

    always_ff @(posedge i_clk) begin
        if (s_en[SC+2]) begin
            r_fx3 <= 33'(r_fx2);
            r_fy3 <= 33'(r_fy2);
            r_fz3 <= 33'(r_fz2);
            r_rx3 <= 33'(r_crsy2) - 33'(r_ax);
            r_ry3 <= -33'(r_ay) - 33'(r_crcy2);
            r_rz3 <= 33'(r_rz2);
            r_ux3 <= 33'(r_bx) + 33'(r_srsy2);
            r_uy3 <= 33'(r_by) - 33'(r_srcy2);
            r_uz3 <= 33'(r_uz2);
        end
    end

    // Output stage: round and saturate
    always_ff @(posedge i_clk) begin
        if (s_en[SC+3]) begin
            o_out_data.fwd_x   <= to_out(r_fx3);
            o_out_data.fwd_y   <= to_out(r_fy3);
            o_out_data.fwd_z   <= to_out(r_fz3);
            o_out_data.right_x <= to_out(r_rx3);
            o_out_data.right_y <= to_out(r_ry3);
            o_out_data.right_z <= to_out(r_rz3);
            o_out_data.up_x    <= to_out(r_ux3);
            o_out_data.up_y    <= to_out(r_uy3);
            o_out_data.up_z    <= to_out(r_uz3);
        end
    end

    // Checks
    `EAB_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_in_valid && o_in_ready, r_v[0], "accepted beat did not enter stage 0")
    `EAB_ASSERT_IMPL(a_ready_only_stall, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready, "input stalled without output stall")
    `EAB_ASSERT_IMPL(a_drain_frees_input, i_clk, i_rst_n, o_out_valid && i_out_ready, o_in_ready, "output taken but input not ready")

endmodule

`default_nettype wire

>>> hdl/eab_sincos.sv
// ----------------------------------------------------------------------------
// eab_sincos
// Pipelined sine/cosine of one angle: range reduction, octant fold, and
// Horner evaluation of both Taylor series, a multiply and a divide stage per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eab_sincos #(
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  wire                              i_clk,
    input  wire [eab_pkg::SC_STAGES-1:0]     i_en,
    input  wire signed [15:0]                i_angle,
    output logic signed [31:0]               o_sin,
    output logic signed [31:0]               o_cos
);

    // Angle constants
    localparam longint unsigned UNIT     = 64'd1 << ANGLE_FRAC_BITS;
    localparam longint unsigned TURN     = 360 * UNIT;
    localparam longint unsigned QUARTER  = 90 * UNIT;
    localparam longint unsigned HALF_OCT = 45 * UNIT;
    localparam longint unsigned OFFS     = TURN * ((32768 + TURN - 1) / TURN);
    localparam longint unsigned MT       = (64'd1 << 32) / TURN;
    localparam longint unsigned QMAX     = (OFFS + 32768) / TURN;

    localparam int AUW = $clog2(OFFS + 32768);
    localparam int QW  = $clog2(QMAX + 1);
    localparam int RW  = $clog2(2 * TURN);
    localparam int TW  = $clog2(TURN);
    localparam int FW  = $clog2(QUARTER);
    localparam int GW  = $clog2(HALF_OCT + 1);
    localparam int PW  = GW + 25;

    // Stage map
    localparam int ST_HORNER = 6;
    localparam int ST_FINAL  = ST_HORNER + 2 * eab_pkg::NUM_STEPS;

    // Stage 0: offset to non-negative, quotient estimate
    logic [AUW:0]     s_au_full;
    logic [AUW-1:0]   s_au;
    logic [AUW+31:0]  s_pq;
    logic [AUW-1:0]   r_au;
    logic [QW-1:0]    r_qe;

    assign s_au_full = {{(AUW - 15){i_angle[15]}}, i_angle} + (AUW + 1)'(OFFS);
    assign s_au      = s_au_full[AUW-1:0];
    assign s_pq      = (AUW + 32)'(s_au) * (AUW + 32)'(MT);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_au <= s_au;
            r_qe <= QW'(s_pq >> 32);
        end
    end

    // Stage 1: remainder, below two turns
    logic [AUW-1:0] s_qt;
    logic [RW-1:0]  r_r0;

    assign s_qt = AUW'(64'(r_qe) * TURN);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_r0 <= RW'(r_au - s_qt);
        end
    end

    // Stage 2: final correction into one turn
    logic [TW-1:0] r_r;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_r <= (r_r0 >= RW'(TURN)) ? TW'(r_r0 - RW'(TURN)) : TW'(r_r0);
        end
    end

    // Stage 3: quadrant and octant fold
    eab_pkg::t_quad s_quad;
    logic [FW-1:0]  s_f;
    logic [GW-1:0]  s_g;
    logic           s_swap;
    logic [GW-1:0]  r_g;
    eab_pkg::t_quad r_qd [3:17];
    logic           r_sw [3:17];

    always_comb begin
        if (r_r >= TW'(3 * QUARTER)) begin
            s_quad = eab_pkg::QUAD_3;
            s_f    = FW'(r_r - TW'(3 * QUARTER));
        end else if (r_r >= TW'(2 * QUARTER)) begin
            s_quad = eab_pkg::QUAD_2;
            s_f    = FW'(r_r - TW'(2 * QUARTER));
        end else if (r_r >= TW'(QUARTER)) begin
            s_quad = eab_pkg::QUAD_1;
            s_f    = FW'(r_r - TW'(QUARTER));
        end else begin
            s_quad = eab_pkg::QUAD_0;
            s_f    = FW'(r_r);
        end
        s_swap = (s_f > FW'(HALF_OCT));
        s_g    = s_swap ? GW'(FW'(QUARTER) - s_f) : GW'(s_f);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_g     <= s_g;
            r_qd[3] <= s_quad;
            r_sw[3] <= s_swap;
        end
    end

    // Quadrant and swap flag ride along to the final stage
    for (genvar s = 4; s <= 17; s++) begin : g_flag
        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_qd[s] <= r_qd[s-1];
                r_sw[s] <= r_sw[s-1];
            end
        end
    end

    // Stage 4: degrees to radians, Q30
    logic [PW-1:0] s_xp;
    logic [29:0]   r_x;

    assign s_xp = PW'(r_g) * PW'(eab_pkg::DEG_TO_RAD_Q30) + PW'(UNIT / 2);

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_x <= 30'(s_xp >> ANGLE_FRAC_BITS);
        end
    end

    // Stage 5: x squared; x and x^2 then ride along the Horner stages
    logic [59:0] s_xx;
    logic [30:0] r_x2p [5:15];
    logic [29:0] r_xp  [5:15];

    assign s_xx = 60'(r_x) * 60'(r_x);

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_x2p[5] <= 31'((61'(s_xx) + eab_pkg::HALF_P) >> eab_pkg::IFB);
            r_xp[5]  <= r_x;
        end
    end

    for (genvar s = 6; s <= 15; s++) begin : g_xdly
        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_x2p[s] <= r_x2p[s-1];
                r_xp[s]  <= r_xp[s-1];
            end
        end
    end

    // Horner steps: stage A multiplies, stage B divides by a constant
    logic [60:0] r_ca [6];
    logic [29:0] r_cb [6];
    logic [60:0] r_sa [6];
    logic [30:0] r_sb [6];

    for (genvar j = 0; j < 6; j++) begin : g_step
        localparam int SA = ST_HORNER + 2 * j;
        localparam int SB = SA + 1;
        localparam longint unsigned CN = eab_pkg::COS_DEN[j];
        localparam int CK = 31 + $clog2(CN);
        localparam logic [32:0] CM = 33'(((64'd1 << CK) + CN - 1) / CN);

        logic [30:0] c_t;
        logic [30:0] s_t;
        logic [30:0] c_w;
        logic [63:0] c_m;

        if (j == 0) begin : g_first
            assign c_t = eab_pkg::ONE_Q;
            assign s_t = eab_pkg::ONE_Q;
        end else begin : g_next
            assign c_t = eab_pkg::ONE_Q - 31'(r_cb[j-1]);
            assign s_t = eab_pkg::ONE_Q - r_sb[j-1];
        end

        // Cosine chain
        assign c_w = 31'((r_ca[j] + eab_pkg::HALF_P) >> eab_pkg::IFB) + 31'(CN / 2);
        assign c_m = 64'(c_w) * 64'(CM);

        always_ff @(posedge i_clk) begin
            if (i_en[SA]) begin
                r_ca[j] <= 61'(r_x2p[SA-1]) * 61'(c_t);
            end
            if (i_en[SB]) begin
                r_cb[j] <= 30'(c_m >> CK);
            end
        end

        // Sine chain; its last slot multiplies by x
        if (j < 5) begin : g_sin_step
            localparam longint unsigned SN = eab_pkg::SIN_DEN[j];
            localparam int SK = 31 + $clog2(SN);
            localparam logic [32:0] SM = 33'(((64'd1 << SK) + SN - 1) / SN);

            logic [30:0] w;
            logic [63:0] m;

            assign w = 31'((r_sa[j] + eab_pkg::HALF_P) >> eab_pkg::IFB) + 31'(SN / 2);
            assign m = 64'(w) * 64'(SM);

            always_ff @(posedge i_clk) begin
                if (i_en[SA]) begin
                    r_sa[j] <= 61'(r_x2p[SA-1]) * 61'(s_t);
                end
                if (i_en[SB]) begin
                    r_sb[j] <= 31'(m >> SK);
                end
            end
        end else begin : g_sin_last
            always_ff @(posedge i_clk) begin
                if (i_en[SA]) begin
                    r_sa[j] <= 61'(r_xp[SA-1]) * 61'(s_t);
                end
                if (i_en[SB]) begin
                    r_sb[j] <= 31'((r_sa[j] + eab_pkg::HALF_P) >> eab_pkg::IFB);
                end
            end
        end
    end

    // Final stage: undo octant fold, apply quadrant signs
    logic [30:0]        s_pc;
    logic [30:0]        s_ps;
    logic signed [31:0] s_a;
    logic signed [31:0] s_b;
    logic signed [31:0] s_sin;
    logic signed [31:0] s_cos;

    always_comb begin
        s_pc = eab_pkg::ONE_Q - 31'(r_cb[5]);
        s_ps = r_sb[5];
        s_a  = r_sw[17] ? 32'(s_pc) : 32'(s_ps);
        s_b  = r_sw[17] ? 32'(s_ps) : 32'(s_pc);
        case (r_qd[17])
            eab_pkg::QUAD_0: begin
                s_sin = s_a;
                s_cos = s_b;
            end
            eab_pkg::QUAD_1: begin
                s_sin = s_b;
                s_cos = -s_a;
            end
            eab_pkg::QUAD_2: begin
                s_sin = -s_a;
                s_cos = -s_b;
            end
            default: begin
                s_sin = -s_b;
                s_cos = s_a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_FINAL]) begin
            o_sin <= s_sin;
            o_cos <= s_cos;
        end
    end

endmodule

`default_nettype wire

>>> test/tb_euler_angles_to_basis_vectors_unit.sv
// ----------------------------------------------------------------------------
// tb_euler_angles_to_basis_vectors_unit
// Streams pitch/yaw/roll beats through the unit and checks every output beat
// against a bit-exact fixed point predictor of the forward/right/up vectors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_euler_angles_to_basis_vectors_unit;

    localparam int LATENCY = 23;
    localparam int N_RAND  = 1750;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    eab_pkg::t_in_beat   i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    eab_pkg::t_out_beat  o_out_data;

    euler_angles_to_basis_vectors_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    eab_pkg::t_in_beat  angle_q[$];
    eab_pkg::t_out_beat vec_q[$];
    int        err_cnt;
    int        idle_mode;      // 0: sender 26%/rcv 85%, 1: swapped, 2: none
    int        hold_cycles;    // long receiver stall counter
    bit        stim_done;
    logic      o_in_ready_seen; // acceptance seen at the last rising edge

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor: Q30 arithmetic, 64-bit intermediates
    // ------------------------------------------------------------------------
    function automatic longint umul30(longint a, longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic longint udiv_rnd(longint v, longint n);
        return (v + n / 2) / n;
    endfunction

    function automatic longint smul30(longint a, longint b);
        longint p;
        longint m;
        p = a * b;
        m = (p < 0) ? -p : p;
        m = (m + (longint'(1) << 29)) >>> 30;
        return (p < 0) ? -m : m;
    endfunction

    function automatic longint poly_sin(longint x);
        longint x2;
        longint t;
        int     dn [5];
        dn = '{110, 72, 42, 20, 6};
        x2 = umul30(x, x);
        t = longint'(1) << 30;
        for (int i = 0; i < 5; i++)
            t = (longint'(1) << 30) - udiv_rnd(umul30(x2, t), dn[i]);
        return umul30(x, t);
    endfunction

    function automatic longint poly_cos(longint x);
        longint x2;
        longint t;
        int     dn [6];
        dn = '{132, 90, 56, 30, 12, 2};
        x2 = umul30(x, x);
        t = longint'(1) << 30;
        for (int i = 0; i < 6; i++)
            t = (longint'(1) << 30) - udiv_rnd(umul30(x2, t), dn[i]);
        return t;
    endfunction

    function automatic longint deg_to_rad(longint f);
        return (f * 18740330 + 32) / 64;
    endfunction

    function automatic void angle_sin_cos(input logic signed [15:0] ang,
                                          output longint s, output longint c);
        longint a;
        longint r;
        longint f;
        longint ps;
        longint pc;
        eab_pkg::t_quad q;
        a = ang;
        r = a % 23040;
        if (r < 0) r += 23040;
        q = eab_pkg::t_quad'(r / 5760);
        f = r % 5760;
        if (f <= 2880) begin
            ps = poly_sin(deg_to_rad(f));
            pc = poly_cos(deg_to_rad(f));
        end else begin
            ps = poly_cos(deg_to_rad(5760 - f));
            pc = poly_sin(deg_to_rad(5760 - f));
        end
        case (q)
            eab_pkg::QUAD_0: begin s = ps;  c = pc;  end
            eab_pkg::QUAD_1: begin s = pc;  c = -ps; end
            eab_pkg::QUAD_2: begin s = -ps; c = -pc; end
            default: begin s = -pc; c = ps; end
        endcase
    endfunction

    function automatic logic signed [15:0] q30_to_q15(longint v);
        longint m;
        longint r;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) << 14)) >>> 15;
        if (m > 65536) m = 65536;
        r = (v < 0) ? -m : m;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic eab_pkg::t_out_beat basis_vectors(eab_pkg::t_in_beat a);
        longint sp, cp, sy, cy, sr, cr, srsp, crsp;
        eab_pkg::t_out_beat o;
        angle_sin_cos(a.pitch_angle, sp, cp);
        angle_sin_cos(a.yaw_angle, sy, cy);
        angle_sin_cos(a.roll_angle, sr, cr);
        srsp = smul30(sr, sp);
        crsp = smul30(cr, sp);
        o.fwd_x   = q30_to_q15(smul30(cp, cy));
        o.fwd_y   = q30_to_q15(smul30(cp, sy));
        o.fwd_z   = q30_to_q15(-sp);
        o.right_x = q30_to_q15(-smul30(srsp, cy) + smul30(cr, sy));
        o.right_y = q30_to_q15(-smul30(srsp, sy) - smul30(cr, cy));
        o.right_z = q30_to_q15(-smul30(sr, cp));
        o.up_x    = q30_to_q15(smul30(crsp, cy) + smul30(sr, sy));
        o.up_y    = q30_to_q15(smul30(crsp, sy) - smul30(sr, cy));
        o.up_z    = q30_to_q15(smul30(cr, cp));
        return o;
    endfunction

    task automatic report_mismatch(input string fld, input int got, input int exp_v);
        $display("ERROR %t: %s got %0d expected %0d", $realtime, fld, got, exp_v);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: new beat offered at falling edge, kept until accepted
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || o_in_ready_seen) begin
                if (angle_q.size() > 0 &&
                    !(idle_mode == 0 && $urandom_range(99) < 26) &&
                    !(idle_mode == 1 && $urandom_range(99) < 85)) begin
                    i_in_data  <= angle_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random backpressure plus a counted long stall
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !((idle_mode == 0 && $urandom_range(99) < 85) ||
                                 (idle_mode == 1 && $urandom_range(99) < 26));
            end
        end
    end

    // Record accepted beats and their expected vectors
    always @(posedge i_clk) begin
        o_in_ready_seen <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            vec_q.insert(vec_q.size(), basis_vectors(i_in_data));
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each output beat with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        eab_pkg::t_out_beat e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (vec_q.size() == 0) begin
                report_mismatch("queued beats", 0, 1);
            end else begin
                e = vec_q.pop_front();
                if (o_out_data.fwd_x !== e.fwd_x)
                    report_mismatch("fwd_x", o_out_data.fwd_x, e.fwd_x);
                if (o_out_data.fwd_y !== e.fwd_y)
                    report_mismatch("fwd_y", o_out_data.fwd_y, e.fwd_y);
                if (o_out_data.fwd_z !== e.fwd_z)
                    report_mismatch("fwd_z", o_out_data.fwd_z, e.fwd_z);
                if (o_out_data.right_x !== e.right_x)
                    report_mismatch("right_x", o_out_data.right_x, e.right_x);
                if (o_out_data.right_y !== e.right_y)
                    report_mismatch("right_y", o_out_data.right_y, e.right_y);
                if (o_out_data.right_z !== e.right_z)
                    report_mismatch("right_z", o_out_data.right_z, e.right_z);
                if (o_out_data.up_x !== e.up_x)
                    report_mismatch("up_x", o_out_data.up_x, e.up_x);
                if (o_out_data.up_y !== e.up_y)
                    report_mismatch("up_y", o_out_data.up_y, e.up_y);
                if (o_out_data.up_z !== e.up_z)
                    report_mismatch("up_z", o_out_data.up_z, e.up_z);
            end
        end
    end

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(9))
            0: return 16'($urandom);                   // full 16-bit range, wraps
            1: return 16'(int'($urandom_range(8)) * 2880 - 11520); // octant points
            2: return 16'(int'($urandom_range(8)) * 2880 - 11520
                          + int'($urandom_range(2)) - 1);
            default: return 16'(int'($urandom_range(46080)) - 23040);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        eab_pkg::t_in_beat b;
        logic signed [15:0] pts [12];
        pts = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd5760, -16'sd5760, 16'sd2880,
                16'sd2881, 16'sd11520, 16'sd17280, 16'sh7FFF, -16'sh8000, 16'sd1};
        err_cnt = 0;
        idle_mode = 2;
        hold_cycles = 0;
        stim_done = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        o_in_ready_seen = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed corners: wrap points, quadrant and octant edges, extremes
        for (int i = 0; i < 12; i++) begin
            b.pitch_angle = pts[i];
            b.yaw_angle   = pts[(i + 3) % 12];
            b.roll_angle  = pts[(i + 7) % 12];
            angle_q.insert(angle_q.size(), b);
        end
        for (int i = 0; i < 12; i++) begin
            b.pitch_angle = pts[i];
            b.yaw_angle   = pts[i];
            b.roll_angle  = pts[i];
            angle_q.insert(angle_q.size(), b);
        end

        for (int ph = 0; ph < 3; ph++) begin
            idle_mode = ph;
            for (int i = 0; i < N_RAND / 3; i++) begin
                b.pitch_angle = rand_angle();
                b.yaw_angle   = rand_angle();
                b.roll_angle  = rand_angle();
                angle_q.insert(angle_q.size(), b);
            end
            if (ph == 2) hold_cycles = 200;   // long stall fills the pipeline
            while (angle_q.size() > 0 || i_in_valid) @(posedge i_clk);
        end

        while (vec_q.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (err_cnt == 0)
            $display("PASS euler_angles_to_basis_vectors_unit");
        else
            $display("FAIL euler_angles_to_basis_vectors_unit");
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("FAIL euler_angles_to_basis_vectors_unit");
        $finish;
    end

endmodule
